>>> rtl/sse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sse_pkg
// Shared constants, opcodes and control types for the sparse set engine.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int unsigned UNIVERSE_DEF = 256;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_GET      = 3'd4
  } sse_op_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_sparse;
    logic rd_dense;
    logic commit;
  } sse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
  } sse_stat_t;

endpackage : sse_pkg
`default_nettype wire

>>> rtl/sse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sse_ctrl
// Sequencer for one operation: capture, sparse read, dense read, execute.
// ----------------------------------------------------------------------------
module sse_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sse_pkg::sse_stat_t stat,
  output sse_pkg::sse_cmd_t      cmd
);
  import sse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RD_SPRS = 4'b0010,
    ST_RD_DNS  = 4'b0100,
    ST_EXEC    = 4'b1000
  } sse_state_t;

  sse_state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.rd_sparse = 1'b0;
    cmd.rd_dense  = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RD_SPRS;
        end
      end
      ST_RD_SPRS: begin
        cmd.rd_sparse = 1'b1;
        state_nxt     = ST_RD_DNS;
      end
      ST_RD_DNS: begin
        cmd.rd_dense = 1'b1;
        state_nxt    = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule : sse_ctrl
`default_nettype wire

>>> rtl/sse_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sse_datapath
// Dense and sparse stores, member count, universe register and result register.
// ----------------------------------------------------------------------------
module sse_datapath #(
  parameter int unsigned UNIVERSE = sse_pkg::UNIVERSE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sse_pkg::sse_cmd_t             cmd,
  output sse_pkg::sse_stat_t                 stat,
  input  wire logic [sse_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [sse_pkg::VALUE_W-1:0]   in_value,
  input  wire logic [sse_pkg::VALUE_W-1:0]   in_position,
  input  wire logic                          cfg_we,
  input  wire logic [sse_pkg::COUNT_W-1:0]   cfg_universe_size,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic                               out_present,
  output logic [sse_pkg::VALUE_W-1:0]        out_element,
  output logic [sse_pkg::COUNT_W-1:0]        out_member_count
);
  import sse_pkg::*;

  localparam int unsigned DEPTH = (UNIVERSE < 256) ? UNIVERSE : 256;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_W = COUNT_W'(DEPTH);
  localparam logic [COUNT_W-1:0] USZ_RST = COUNT_W'(256);

  bit [VALUE_W-1:0]   dense_mem  [DEPTH];
  bit [AW-1:0]        sparse_mem [DEPTH];

  logic [OP_W-1:0]    op_r;
  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] pos_r;
  logic [AW-1:0]      slot_r;
  logic [VALUE_W-1:0] dense_a_r;
  logic [VALUE_W-1:0] dense_b_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] usz_r;

  logic               out_valid_r;
  logic               status_r, status_nxt;
  logic               present_r, present_nxt;
  logic [VALUE_W-1:0] element_r, element_nxt;

  logic [COUNT_W-1:0] last;
  logic               in_range;
  logic               member;
  logic               slot_ok;
  logic [AW-1:0]      dense_a_addr;

  logic               dense_we;
  logic [AW-1:0]      dense_waddr;
  logic [VALUE_W-1:0] dense_wdata;
  logic               sparse_we;
  logic [AW-1:0]      sparse_waddr;
  logic [AW-1:0]      sparse_wdata;

  assign last     = count_r - COUNT_W'(1);
  assign in_range = ({1'b0, value_r} < usz_r) && ({1'b0, value_r} < DEPTH_W);
  assign slot_ok  = (COUNT_W'(slot_r) < count_r);
  assign member   = in_range && slot_ok && (dense_a_r == value_r);
  assign dense_a_addr = (op_r == OP_GET) ? pos_r[AW-1:0] : slot_r;

  // execute
  always_comb begin
    count_nxt    = count_r;
    status_nxt   = 1'b1;
    present_nxt  = 1'b0;
    element_nxt  = '0;
    dense_we     = 1'b0;
    dense_waddr  = count_r[AW-1:0];
    dense_wdata  = value_r;
    sparse_we    = 1'b0;
    sparse_waddr = value_r[AW-1:0];
    sparse_wdata = count_r[AW-1:0];
    case (op_r)
      OP_ADD: begin
        if (in_range) begin
          if (member) begin
            status_nxt = 1'b0;
          end else if (count_r < DEPTH_W) begin
            dense_we   = 1'b1;
            sparse_we  = 1'b1;
            count_nxt  = count_r + COUNT_W'(1);
            status_nxt = 1'b0;
          end
        end
      end
      OP_REMOVE: begin
        if (member) begin
          if (COUNT_W'(slot_r) < last) begin
            dense_we     = 1'b1;
            dense_waddr  = slot_r;
            dense_wdata  = dense_b_r;
            sparse_we    = 1'b1;
            sparse_waddr = dense_b_r[AW-1:0];
            sparse_wdata = slot_r;
          end
          count_nxt  = last;
          status_nxt = 1'b0;
        end
      end
      OP_CONTAINS: begin
        if (in_range) begin
          status_nxt  = 1'b0;
          present_nxt = member;
        end
      end
      OP_CLEAR: begin
        count_nxt  = '0;
        status_nxt = 1'b0;
      end
      OP_GET: begin
        if ({1'b0, pos_r} < count_r) begin
          element_nxt = dense_a_r;
          status_nxt  = 1'b0;
        end
      end
      default: status_nxt = 1'b1;
    endcase
  end

  // operand capture and memory reads
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd.rd_sparse) begin
      slot_r <= sparse_mem[value_r[AW-1:0]];
    end
    if (cmd.rd_dense) begin
      dense_a_r <= dense_mem[dense_a_addr];
      dense_b_r <= dense_mem[last[AW-1:0]];
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.commit && dense_we) begin
      dense_mem[dense_waddr] <= dense_wdata;
    end
    if (cmd.commit && sparse_we) begin
      sparse_mem[sparse_waddr] <= sparse_wdata;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status_nxt;
      present_r <= present_nxt;
      element_r <= element_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      usz_r       <= USZ_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        usz_r <= cfg_universe_size;
      end
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_full    = out_valid_r && out_stall;
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_present      = present_r;
  assign out_element      = element_r;
  assign out_member_count = count_r;

endmodule : sse_datapath
`default_nettype wire

>>> rtl/sparse_set_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_set_engine
// Sparse set of small integers with add, remove, contains, clear and get-at.
// ----------------------------------------------------------------------------
// Each operation runs through four steps from acceptance to a loaded result: one
// to take the transaction, one to read the back-index store at the value, one to
// read the member store (at the back-index slot and at the last member, or at
// the position for get-at) and one to execute, write both stores and load the
// result register. A new transaction is taken while a result waits; it
// holds in the execute step only while an earlier result is still stalled.
// The stores are never cleared, there is no start-up pass, and clear takes
// effect in one step. Values at or above universe_size are rejected. The user
// must write it via the cfg port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sparse_set_engine #(
  parameter int unsigned UNIVERSE = sse_pkg::UNIVERSE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sse_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [sse_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [sse_pkg::VALUE_W-1:0]  in_position,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_status,
  output logic                              out_present,
  output logic [sse_pkg::VALUE_W-1:0]       out_element,
  output logic [sse_pkg::COUNT_W-1:0]       out_member_count,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sse_pkg::COUNT_W-1:0]  cfg_universe_size
);
  import sse_pkg::*;

  localparam int unsigned DEPTH = (UNIVERSE < 256) ? UNIVERSE : 256;

  sse_cmd_t  cmd;
  sse_stat_t stat;

  assign cfg_ready = 1'b1;

  sse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sse_datapath #(
    .UNIVERSE (UNIVERSE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_value          (in_value),
    .in_position       (in_position),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_universe_size (cfg_universe_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_present       (out_present),
    .out_element       (out_element),
    .out_member_count  (out_member_count)
  );

  // a transaction taken is followed by a valid result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##4 out_valid)
    else $error("result missing after accepted transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken during an operation");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_member_count <= COUNT_W'(DEPTH)))
    else $error("member count beyond store depth");

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (!out_present && (out_element == '0)))
    else $error("failed result carries data");

endmodule : sparse_set_engine
`default_nettype wire
